>>> rtl/gda_pkg.sv
// gda_pkg: shared types, constants and calendar functions for the gregorian date core
// depends on nothing; imported by every module of the block
package gda_pkg;

	localparam int DEFAULT_COUNT_WIDTH = 16;
	localparam int DEFAULT_YEAR_WIDTH  = 16;

	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
	localparam logic [3:0] MONTH_JAN       = 4'd1;
	localparam logic [3:0] MONTH_FEB       = 4'd2;
	localparam logic [4:0] DAY_FIRST       = 5'd1;
	localparam logic [5:0] RES_MOD         = 6'd25;
	localparam logic [4:0] RES_LAST        = 5'd24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_ADV,
		ST_DONE
	} gda_state_t;

	// leap test from year mod 16 and year mod 25
	function automatic logic is_leap(input logic [3:0] ylow, input logic [4:0] res25);
		logic by4;
		logic by16;
		by4  = (ylow[1:0] == 2'd0);
		by16 = (ylow == 4'd0);
		return (by4 && (res25 != 5'd0)) || (by16 && (res25 == 5'd0));
	endfunction

	// length of a month, zero for month codes outside the year
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		unique case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = lp ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the months before m, common year; months past twelve count the whole year
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m) inside
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			4'd12:      d = 9'd334;
			default:    d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

>>> rtl/gda_rem25.sv
// gda_rem25: remainder of a year by 25, one shift-and-add fold per cycle
// then a short compare-and-subtract on the last byte; depends on gda_pkg
module gda_rem25 import gda_pkg::*; #(
	parameter int YEAR_WIDTH = DEFAULT_YEAR_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [YEAR_WIDTH-1:0] year,
	output logic                  busy,
	output logic [4:0]            rem
);

	localparam int         ACC_W  = 32;
	localparam logic [7:0] MOD_X1 = 8'(RES_MOD);
	localparam logic [7:0] MOD_X2 = MOD_X1 << 1;
	localparam logic [7:0] MOD_X4 = MOD_X1 << 2;
	localparam logic [7:0] MOD_X8 = MOD_X1 << 3;

	logic [ACC_W-1:0] acc_q;
	logic             busy_q;
	logic             fits;
	logic [ACC_W-1:0] fold;
	logic [7:0]       r1;
	logic [7:0]       r2;
	logic [7:0]       r3;
	logic [7:0]       r4;

	// 256 is 6 mod 25, so the upper part folds back in as 4x + 2x
	always_comb begin
		fits = (acc_q[ACC_W-1:8] == '0);
		fold = ACC_W'(acc_q[7:0]) + ACC_W'({acc_q[ACC_W-1:8], 2'b00})
			+ ACC_W'({acc_q[ACC_W-1:8], 1'b0});
		r1   = (acc_q[7:0] >= MOD_X8) ? (acc_q[7:0] - MOD_X8) : acc_q[7:0];
		r2   = (r1 >= MOD_X4) ? (r1 - MOD_X4) : r1;
		r3   = (r2 >= MOD_X2) ? (r2 - MOD_X2) : r2;
		r4   = (r3 >= MOD_X1) ? (r3 - MOD_X1) : r3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && fits) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= ACC_W'(year);
		end else if (busy_q && !fits) begin
			acc_q <= fold;
		end
	end

	assign busy = busy_q;
	assign rem  = r4[4:0];

endmodule

>>> rtl/gda_step.sv
// gda_step: one advance step of the running date, a day rollover or a run within a month
// depends on gda_pkg
module gda_step import gda_pkg::*; #(
	parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH,
	parameter int YEAR_WIDTH  = DEFAULT_YEAR_WIDTH
) (
	input  logic [4:0]             day,
	input  logic [3:0]             month,
	input  logic [YEAR_WIDTH-1:0]  year,
	input  logic [4:0]             res25,
	input  logic [COUNT_WIDTH-1:0] left,
	output logic [4:0]             day_nx,
	output logic [3:0]             month_nx,
	output logic [YEAR_WIDTH-1:0]  year_nx,
	output logic [4:0]             res25_nx,
	output logic [COUNT_WIDTH-1:0] left_nx
);

	localparam int XW = (COUNT_WIDTH > 5) ? COUNT_WIDTH : 5;

	logic [4:0]    len;
	logic [4:0]    room;
	logic [XW-1:0] left_x;
	logic [XW-1:0] room_x;
	logic [XW-1:0] left_sub;

	always_comb begin
		len      = month_len(month, is_leap(year[3:0], res25));
		room     = len - day;
		left_x   = XW'(left);
		room_x   = XW'(room);
		left_sub = left_x - room_x;
		day_nx   = day;
		month_nx = month;
		year_nx  = year;
		res25_nx = res25;
		left_nx  = left;
		if (day >= len) begin
			// roll over to the first of the next month
			day_nx  = DAY_FIRST;
			left_nx = left - 1'b1;
			if (month >= MONTHS_PER_YEAR) begin
				month_nx = MONTH_JAN;
				year_nx  = year + 1'b1;
				if (year == {YEAR_WIDTH{1'b1}} || res25 == RES_LAST) begin
					res25_nx = 5'd0;
				end else begin
					res25_nx = res25 + 1'b1;
				end
			end else begin
				month_nx = month + 1'b1;
			end
		end else if (left_x <= room_x) begin
			day_nx  = day + left_x[4:0];
			left_nx = '0;
		end else begin
			day_nx  = len;
			left_nx = left_sub[COUNT_WIDTH-1:0];
		end
	end

endmodule

>>> rtl/gregorian_date_arithmetic_core.sv
// gregorian_date_arithmetic_core: top level, sequencer, output register and checks
// depends on gda_pkg, gda_rem25 and gda_step
//
// An item carries a start date, a day count and a comparison date; one result
// item comes back with the advanced date, the start date's day of the year and
// the less / equal flags. The block takes one item at a time: after acceptance
// the year is reduced mod 25 (for the century and 400-year leap rules) by a
// shift-and-add fold, one fold per cycle until the value fits in a byte, at most
// three folds for a 16-bit year and six for a 32-bit one; the date then advances
// one step per cycle through a single step unit, each step either rolling into
// the next month or jumping to the end of the current run, so at most add_count
// steps and usually about two per month crossed. The result sits in an output
// register, so the next item can be taken while a result waits to be read.
module gregorian_date_arithmetic_core import gda_pkg::*; #(
	parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH,
	parameter int YEAR_WIDTH  = DEFAULT_YEAR_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [4:0]             start_day,
	input  logic [3:0]             start_month,
	input  logic [YEAR_WIDTH-1:0]  start_year,
	input  logic [COUNT_WIDTH-1:0] add_count,
	input  logic [4:0]             other_day,
	input  logic [3:0]             other_month,
	input  logic [YEAR_WIDTH-1:0]  other_year,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [4:0]             new_day,
	output logic [3:0]             new_month,
	output logic [YEAR_WIDTH-1:0]  new_year,
	output logic [8:0]             day_of_year,
	output logic                   is_less,
	output logic                   is_equal
);

	gda_state_t state_q, state_d;

	// held copy of the item
	logic [4:0]             sd_q;
	logic [3:0]             sm_q;
	logic [YEAR_WIDTH-1:0]  sy_q;
	logic [4:0]             od_q;
	logic [3:0]             om_q;
	logic [YEAR_WIDTH-1:0]  oy_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	// running date
	logic [4:0]             nd_q;
	logic [3:0]             nm_q;
	logic [YEAR_WIDTH-1:0]  ny_q;
	logic [4:0]             r25_q;
	logic [COUNT_WIDTH-1:0] left_q;

	// output register
	logic                   out_valid_q;
	logic [4:0]             new_day_q;
	logic [3:0]             new_month_q;
	logic [YEAR_WIDTH-1:0]  new_year_q;
	logic [8:0]             doy_q;
	logic                   less_q;
	logic                   equal_q;

	logic                   accept;
	logic                   rem_busy;
	logic [4:0]             rem;
	logic                   load_out;
	logic                   step_en;

	logic [4:0]             day_nx;
	logic [3:0]             month_nx;
	logic [YEAR_WIDTH-1:0]  year_nx;
	logic [4:0]             res25_nx;
	logic [COUNT_WIDTH-1:0] left_nx;

	logic [8:0]             doy;
	logic                   less;
	logic                   equal;

	assign accept = in_valid && in_ready;

	gda_rem25 #(
		.YEAR_WIDTH(YEAR_WIDTH)
	) u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.year  (start_year),
		.busy  (rem_busy),
		.rem   (rem)
	);

	gda_step #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.YEAR_WIDTH (YEAR_WIDTH)
	) u_step (
		.day     (nd_q),
		.month   (nm_q),
		.year    (ny_q),
		.res25   (r25_q),
		.left    (left_q),
		.day_nx  (day_nx),
		.month_nx(month_nx),
		.year_nx (year_nx),
		.res25_nx(res25_nx),
		.left_nx (left_nx)
	);

	// sequencer: take item, reduce year, step the date, hand over the result
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		step_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (!rem_busy) begin
					state_d = ST_ADV;
				end
			end
			ST_ADV: begin
				if (left_q == '0) begin
					state_d = ST_DONE;
				end else begin
					step_en = 1'b1;
				end
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sd_q   <= start_day;
			sm_q   <= start_month;
			sy_q   <= start_year;
			od_q   <= other_day;
			om_q   <= other_month;
			oy_q   <= other_year;
			cnt_q  <= add_count;
			nd_q   <= start_day;
			nm_q   <= start_month;
			ny_q   <= start_year;
			left_q <= add_count;
		end else if (state_q == ST_MOD && !rem_busy) begin
			r25_q <= rem;
		end else if (step_en) begin
			nd_q   <= day_nx;
			nm_q   <= month_nx;
			ny_q   <= year_nx;
			r25_q  <= res25_nx;
			left_q <= left_nx;
		end
	end

	// day of year and comparison of the held start date, remainder still in u_rem
	always_comb begin
		doy = 9'(sd_q) + days_before(sm_q);
		if (sm_q > MONTH_FEB && is_leap(sy_q[3:0], rem)) begin
			doy = doy + 9'd1;
		end
		equal = (sd_q == od_q) && (sm_q == om_q) && (sy_q == oy_q);
		if (sy_q != oy_q) begin
			less = sy_q < oy_q;
		end else if (sm_q != om_q) begin
			less = sm_q < om_q;
		end else begin
			less = sd_q < od_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			new_day_q   <= nd_q;
			new_month_q <= nm_q;
			new_year_q  <= ny_q;
			doy_q       <= doy;
			less_q      <= less;
			equal_q     <= equal;
		end
	end

	assign out_valid   = out_valid_q;
	assign new_day     = new_day_q;
	assign new_month   = new_month_q;
	assign new_year    = new_year_q;
	assign day_of_year = doy_q;
	assign is_less     = less_q;
	assign is_equal    = equal_q;

	// every step takes at least one day off the count
	assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> (left_q < $past(left_q)))
		else $error("date step did not reduce the day count");

	// the year residue stays below the modulus once it is in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV) |-> (r25_q < 5'd25))
		else $error("year residue out of range");

	// a date that has been advanced lands in a real month
	assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && cnt_q != '0) |-> (nm_q >= MONTH_JAN && nm_q <= MONTHS_PER_YEAR))
		else $error("advanced date has an invalid month");

	// a result only appears out of the hand-over state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside hand-over");

endmodule

>>> bench/tb_gregorian_date_arithmetic_core.sv
// tb_gregorian_date_arithmetic_core: self-checking bench for the gregorian date core
// drives date queries over valid/ready, predicts or looks up each result, checks each field
// depends on gda_pkg and gregorian_date_arithmetic_core
module tb_gregorian_date_arithmetic_core;

	localparam int CW = gda_pkg::DEFAULT_COUNT_WIDTH;
	localparam int YW = gda_pkg::DEFAULT_YEAR_WIDTH;
	localparam int N_DIRECTED = 22;
	localparam int N_RANDOM = 78;

	// year first, so a packed compare orders dates by year, then month, then day
	typedef struct packed {
		logic [YW-1:0] year;
		logic [3:0]    month;
		logic [4:0]    day;
	} cal_date_t;

	typedef struct packed {
		cal_date_t     start;
		logic [CW-1:0] days;
		cal_date_t     other;
	} date_query_t;

	typedef struct packed {
		cal_date_t  moved;
		logic [8:0] ordinal;
		logic       earlier;
		logic       same;
	} date_answer_t;

	localparam int QW = $bits(date_query_t);

	// dates written day, month, year; known rows carry a typed-in answer
	typedef struct packed {
		logic [4:0]    sd;
		logic [3:0]    sm;
		logic [YW-1:0] sy;
		logic [CW-1:0] cnt;
		logic [4:0]    od;
		logic [3:0]    om;
		logic [YW-1:0] oy;
		logic          known;
		logic [4:0]    ed;
		logic [3:0]    em;
		logic [YW-1:0] ey;
		logic [8:0]    edoy;
		logic          eless;
		logic          eeq;
	} directed_row_t;

	directed_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{1, 1, 2000, 0, 1, 1, 2000, 1, 1, 1, 2000, 1, 0, 1},
		'{31, 12, 1999, 1, 1, 1, 2000, 1, 1, 1, 2000, 365, 1, 0},
		'{28, 2, 2000, 1, 28, 2, 2000, 1, 29, 2, 2000, 59, 0, 1},
		'{28, 2, 1900, 1, 1, 3, 1900, 1, 1, 3, 1900, 59, 1, 0},
		'{28, 2, 2023, 1, 27, 2, 2023, 1, 1, 3, 2023, 59, 0, 0},
		'{28, 2, 0, 1, 28, 2, 1, 1, 29, 2, 0, 59, 1, 0},
		'{31, 12, 65535, 1, 31, 12, 65535, 1, 1, 1, 0, 365, 0, 1},
		'{31, 12, 2000, 0, 0, 0, 0, 1, 31, 12, 2000, 366, 0, 0},
		'{15, 0, 2000, 1, 15, 0, 2000, 1, 1, 1, 2000, 15, 0, 1},
		'{5, 13, 10, 1, 5, 14, 10, 1, 1, 1, 11, 370, 1, 0},
		'{31, 15, 65535, 1, 31, 15, 65535, 1, 1, 1, 0, 396, 0, 1},
		'{0, 1, 2001, 0, 1, 1, 2001, 1, 0, 1, 2001, 0, 1, 0},
		'{31, 4, 2001, 1, 31, 4, 2001, 1, 1, 5, 2001, 121, 0, 1},
		'{1, 1, 0, 65535, 31, 15, 65535, 0, 0, 0, 0, 0, 0, 0},
		'{29, 2, 2000, 365, 1, 3, 2001, 0, 0, 0, 0, 0, 0, 0},
		'{15, 6, 2024, 12345, 15, 6, 2024, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 40, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{31, 2, 2023, 3, 30, 2, 2023, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 1, 43690, 2, 1, 1, 0, 0, 0, 0, 0, 0, 0},
		'{10, 7, 1600, 21845, 10, 8, 1600, 0, 0, 0, 0, 0, 0, 0},
		'{31, 12, 65535, 65535, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{30, 11, 2100, 31, 1, 12, 2100, 0, 0, 0, 0, 0, 0, 0}
	};

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [4:0]    start_day = '0;
	logic [3:0]    start_month = '0;
	logic [YW-1:0] start_year = '0;
	logic [CW-1:0] add_count = '0;
	logic [4:0]    other_day = '0;
	logic [3:0]    other_month = '0;
	logic [YW-1:0] other_year = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [4:0]    new_day;
	logic [3:0]    new_month;
	logic [YW-1:0] new_year;
	logic [8:0]    day_of_year;
	logic          is_less;
	logic          is_equal;

	date_answer_t expected_dates[$];
	bit           failed = 1'b0;
	bit           steady = 1'b0;
	int unsigned  offered = 0;

	gregorian_date_arithmetic_core #(
		.COUNT_WIDTH(CW),
		.YEAR_WIDTH (YW)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_day  (start_day),
		.start_month(start_month),
		.start_year (start_year),
		.add_count  (add_count),
		.other_day  (other_day),
		.other_month(other_month),
		.other_year (other_year),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.new_day    (new_day),
		.new_month  (new_month),
		.new_year   (new_year),
		.day_of_year(day_of_year),
		.is_less    (is_less),
		.is_equal   (is_equal)
	);

	always #5 clk = ~clk;

	function automatic bit leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// month codes outside 1..12 have no days
	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		case (m) inside
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic date_answer_t predict_date(date_query_t q);
		int unsigned  d;
		int unsigned  m;
		int unsigned  y;
		int unsigned  left;
		int unsigned  len;
		int unsigned  doy;
		date_answer_t a;
		d = 32'(q.start.day);
		m = 32'(q.start.month);
		y = 32'(q.start.year);
		left = 32'(q.days);
		// jump to the end of each month run, then roll over one day at a time
		while (left > 0) begin
			len = days_in_month(m, y);
			if (d >= len) begin
				d = 1;
				m++;
				if (m > 12) begin
					m = 1;
					y = (y + 1) & ((1 << YW) - 1);
				end
				left--;
			end else if (left <= len - d) begin
				d += left;
				left = 0;
			end else begin
				left -= len - d;
				d = len;
			end
		end
		doy = 32'(q.start.day);
		for (int unsigned i = 1; i < 32'(q.start.month); i++)
			doy += days_in_month(i, 32'(q.start.year));
		a.moved.day = d[4:0];
		a.moved.month = m[3:0];
		a.moved.year = y[YW-1:0];
		a.ordinal = doy[8:0];
		a.earlier = q.start < q.other;
		a.same = q.start == q.other;
		return a;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// present one item, hold it until taken; valid stays high across back-to-back items
	task automatic offer_query(input date_query_t q, input date_answer_t a);
		int unsigned gap;
		if (offered % 20 == 0)
			steady = ($urandom_range(0, 2) == 0);
		offered++;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start_day <= q.start.day;
		start_month <= q.start.month;
		start_year <= q.start.year;
		add_count <= q.days;
		other_day <= q.other.day;
		other_month <= q.other.month;
		other_year <= q.other.year;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_dates.push_back(a);
		@(negedge clk);
	endtask

	initial begin
		directed_row_t r;
		date_query_t   q;
		date_answer_t  a;
		int unsigned   pick;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			q.start.day = r.sd;
			q.start.month = r.sm;
			q.start.year = r.sy;
			q.days = r.cnt;
			q.other.day = r.od;
			q.other.month = r.om;
			q.other.year = r.oy;
			if (r.known) begin
				a.moved.day = r.ed;
				a.moved.month = r.em;
				a.moved.year = r.ey;
				a.ordinal = r.edoy;
				a.earlier = r.eless;
				a.same = r.eeq;
			end else begin
				a = predict_date(q);
			end
			offer_query(q, a);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 9) < 8) begin
				// valid start dates with random content
				pick = $urandom_range(0, 5);
				if (pick == 0)
					q.start.year = YW'($urandom);
				else if (pick == 1)
					q.start.year = YW'($urandom_range((1 << YW) - 4, (1 << YW) - 1));
				else
					q.start.year = YW'($urandom_range(1500, 2500));
				q.start.month = 4'($urandom_range(1, 12));
				if ($urandom_range(0, 3) == 0)
					q.start.day = 5'(days_in_month(32'(q.start.month),
						32'(q.start.year)));
				else
					q.start.day = 5'($urandom_range(1,
						days_in_month(32'(q.start.month), 32'(q.start.year))));
				pick = $urandom_range(0, 9);
				if (pick == 0)
					q.days = CW'($urandom);
				else if (pick < 4)
					q.days = CW'($urandom_range(0, 3));
				else
					q.days = CW'($urandom_range(0, 800));
				q.other = q.start;
				case ($urandom_range(0, 3))
					0: ;
					1: q.other.day = 5'($urandom_range(1, 31));
					2: q.other.month = 4'($urandom_range(1, 12));
					default: begin
						q.other.year = YW'(32'(q.start.year) + 32'd1
							- $urandom_range(0, 2));
						q.other.month = 4'($urandom_range(1, 12));
						q.other.day = 5'($urandom_range(1, 31));
					end
				endcase
			end else begin
				// raw noise: day zero, months past twelve, any year
				q = QW'({$urandom, $urandom, $urandom});
			end
			offer_query(q, predict_date(q));
		end
		in_valid <= 1'b0;

		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		date_answer_t want;
		int unsigned  stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_dates.size() == 0) begin
				$error("result item with no query outstanding");
				failed = 1'b1;
			end else begin
				want = expected_dates.pop_front();
				check_field("new_day", 32'(want.moved.day), 32'(new_day));
				check_field("new_month", 32'(want.moved.month), 32'(new_month));
				check_field("new_year", 32'(want.moved.year), 32'(new_year));
				check_field("day_of_year", 32'(want.ordinal), 32'(day_of_year));
				check_field("is_less", 32'(want.earlier), 32'(is_less));
				check_field("is_equal", 32'(want.same), 32'(is_equal));
			end
			@(negedge clk);
		end
	end

	// time limit for 100 items at the worst case with stalls, taken several times over
	initial begin
		#500000000;
		$display("status: fail");
		$finish;
	end

endmodule
